@@ rtl/delimited_field_splitter_assert.svh @@
// Assertion macros shared by the splitter RTL.
`ifndef DELIMITED_FIELD_SPLITTER_ASSERT_SVH
`define DELIMITED_FIELD_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("splitter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("splitter assertion failed");

`endif

@@ rtl/dfs_pkg.sv @@
`timescale 1ns / 1ps

package dfs_pkg;

   localparam int DEFAULT_MAX_LEN    = 4096;
   localparam int DEFAULT_MAX_FIELDS = 256;
   localparam int DEFAULT_MAX_DELIM  = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int RSP_DEPTH   = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELIMITER_BYTES  = 2'd0,
      CSR_DELIMITER_LENGTH = 2'd1,
      CSR_SKIP_EMPTY       = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   localparam logic [63:0] RESET_DELIMITER_BYTES  = 64'd44;
   localparam logic [3:0]  RESET_DELIMITER_LENGTH = 4'd1;

   typedef struct packed {
      logic        field_present;
      logic [11:0] field_start;
      logic [12:0] field_length;
      logic [7:0]  field_index;
      logic        record_done;
      logic [8:0]  field_count;
      logic        overflow;
   } result_type;

endpackage

@@ rtl/delimited_field_splitter.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_ready  data byte, end of record flag
// rsp_      out        rsp_valid/rsp_ready  one field or closing result
// csr_      in         csr_write_enable     register index, write data
//
// One byte beat is taken per cycle while the queue has room; its results
// enter a four-entry result queue at the accepting edge and leave one per
// cycle while rsp_ready is high, at the earliest in the cycle after the byte.
// A final byte may give two results; input is taken while the queue has
// room for two, which the queue fill level alone decides.
// Synchronous reset clears record state and queue, loads register defaults.

module delimited_field_splitter #(
   parameter int MAX_LEN    = dfs_pkg::DEFAULT_MAX_LEN,
   parameter int MAX_FIELDS = dfs_pkg::DEFAULT_MAX_FIELDS,
   parameter int MAX_DELIM  = dfs_pkg::DEFAULT_MAX_DELIM
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_record,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_field_present,
   output logic [11:0]                    rsp_field_start,
   output logic [12:0]                    rsp_field_length,
   output logic [7:0]                     rsp_field_index,
   output logic                           rsp_record_done,
   output logic [8:0]                     rsp_field_count,
   output logic                           rsp_overflow,

   input  logic                           csr_write_enable,
   input  logic [dfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dfs_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int PW = $clog2(MAX_LEN + 1);
   localparam int FW = $clog2(MAX_FIELDS + 1);
   localparam int WW = 8 * MAX_DELIM;
   localparam int QP = $clog2(dfs_pkg::RSP_DEPTH);
   localparam int QC = $clog2(dfs_pkg::RSP_DEPTH + 1);

   logic [63:0]        delim_ff;
   logic [3:0]         delim_len_ff;
   logic               skip_ff;

   logic [WW-1:0]      win_ff, win_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      cfs_ff, cfs_in;
   logic [FW-1:0]      fields_ff, fields_in;
   logic               ovf_ff, ovf_in;

   dfs_pkg::result_type q_ff [dfs_pkg::RSP_DEPTH];
   logic [QP-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [QC-1:0]      cnt_ff;

   logic               accept, pop;
   logic [3:0]         dl;
   logic               in_range, window_hit, hit;
   logic [PW-1:0]      pos_new, cfs_a, len1, len2, start2;
   logic [FW-1:0]      fields_a, fields_b;
   logic               ovf_a, ovf_b;
   logic               take1, emit1, take2, emit2;
   dfs_pkg::result_type res1, res2;
   logic [1:0]         n_push;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff <= QC'(dfs_pkg::RSP_DEPTH - 2));

   always_comb begin
      if (delim_len_ff == 4'd0) begin
         dl = 4'd1;
      end else if (delim_len_ff > 4'(MAX_DELIM)) begin
         dl = 4'(MAX_DELIM);
      end else begin
         dl = delim_len_ff;
      end
   end

   always_comb begin
      logic m;
      in_range = (pos_ff < PW'(MAX_LEN));
      pos_new  = in_range ? pos_ff + PW'(1) : pos_ff;
      win_in   = in_range ? WW'({win_ff, req_data_byte}) : win_ff;

      window_hit = 1'b0;
      for (int n = 1; n <= MAX_DELIM; n++) begin
         m = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (win_in[8*(n-1-i) +: 8] != delim_ff[8*i +: 8]) begin
               m = 1'b0;
            end
         end
         if (4'(n) == dl) begin
            window_hit = m;
         end
      end

      hit  = in_range && window_hit &&
             ((PW+1)'(pos_new) >= (PW+1)'(cfs_ff) + (PW+1)'(dl));
      len1 = pos_new - PW'(dl) - cfs_ff;

      take1    = hit && !((len1 == '0) && skip_ff);
      emit1    = take1 && (fields_ff < FW'(MAX_FIELDS));
      fields_a = fields_ff + FW'(emit1);
      ovf_a    = ovf_ff || !in_range || (take1 && !emit1);
      cfs_a    = hit ? pos_new : cfs_ff;

      len2     = pos_new - cfs_a;
      take2    = !((len2 == '0) && skip_ff);
      emit2    = take2 && (fields_a < FW'(MAX_FIELDS));
      fields_b = fields_a + FW'(emit2);
      ovf_b    = ovf_a || (take2 && !emit2);
      start2   = (cfs_a > PW'(MAX_LEN - 1)) ? PW'(MAX_LEN - 1) : cfs_a;

      res1.field_present = 1'b1;
      res1.field_start   = 12'(cfs_ff);
      res1.field_length  = 13'(len1);
      res1.field_index   = 8'(fields_ff);
      res1.record_done   = 1'b0;
      res1.field_count   = 9'(fields_a);
      res1.overflow      = ovf_a;

      res2.field_present = emit2;
      res2.field_start   = emit2 ? 12'(start2) : 12'd0;
      res2.field_length  = emit2 ? 13'(len2) : 13'd0;
      res2.field_index   = emit2 ? 8'(fields_a) : 8'd0;
      res2.record_done   = 1'b1;
      res2.field_count   = 9'(fields_b);
      res2.overflow      = ovf_b;

      if (req_end_of_record) begin
         win_in    = '0;
         pos_in    = '0;
         cfs_in    = '0;
         fields_in = '0;
         ovf_in    = 1'b0;
      end else begin
         pos_in    = pos_new;
         cfs_in    = cfs_a;
         fields_in = fields_a;
         ovf_in    = ovf_a;
      end

      n_push = accept ? (2'(emit1) + 2'(req_end_of_record)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff     <= dfs_pkg::RESET_DELIMITER_BYTES;
         delim_len_ff <= dfs_pkg::RESET_DELIMITER_LENGTH;
         skip_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         case (dfs_pkg::csr_index_type'(csr_index))
            dfs_pkg::CSR_DELIMITER_BYTES:  delim_ff     <= csr_write_data;
            dfs_pkg::CSR_DELIMITER_LENGTH: delim_len_ff <= csr_write_data[3:0];
            dfs_pkg::CSR_SKIP_EMPTY:       skip_ff      <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         pos_ff    <= '0;
         cfs_ff    <= '0;
         fields_ff <= '0;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         win_ff    <= win_in;
         pos_ff    <= pos_in;
         cfs_ff    <= cfs_in;
         fields_ff <= fields_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (emit1) begin
            q_ff[wr_ptr_ff] <= res1;
         end
         if (req_end_of_record) begin
            q_ff[wr_ptr_ff + QP'(emit1)] <= res2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QP'(n_push);
         rd_ptr_ff <= rd_ptr_ff + QP'(pop);
         cnt_ff    <= cnt_ff + QC'(n_push) - QC'(pop);
      end
   end

   assign rsp_valid         = (cnt_ff != '0);
   assign rsp_field_present = q_ff[rd_ptr_ff].field_present;
   assign rsp_field_start   = q_ff[rd_ptr_ff].field_start;
   assign rsp_field_length  = q_ff[rd_ptr_ff].field_length;
   assign rsp_field_index   = q_ff[rd_ptr_ff].field_index;
   assign rsp_record_done   = q_ff[rd_ptr_ff].record_done;
   assign rsp_field_count   = q_ff[rd_ptr_ff].field_count;
   assign rsp_overflow      = q_ff[rd_ptr_ff].overflow;

`include "delimited_field_splitter_assert.svh"

   `DFS_ASSERT_NEXT(a_close_gives_beat, clock, reset, accept && req_end_of_record, rsp_valid)
   `DFS_ASSERT_SAME(a_pos_in_limit, clock, reset, 1'b1, pos_ff <= PW'(MAX_LEN))
   `DFS_ASSERT_SAME(a_fields_in_limit, clock, reset, 1'b1, fields_ff <= FW'(MAX_FIELDS))
   `DFS_ASSERT_SAME(a_field_start_order, clock, reset, 1'b1, cfs_ff <= pos_ff)
   `DFS_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, cnt_ff <= QC'(dfs_pkg::RSP_DEPTH))

endmodule

@@ verif/delimited_field_splitter_test.sv @@
`timescale 1ns / 1ps

class split_ledger;
   logic [63:0] delim_bytes;
   logic [3:0]  delim_len;
   bit          skip_empty;

   logic [63:0] window;
   int          position;
   int          field_begin;
   int          fields_taken;
   bit          overflow_seen;

   dfs_pkg::result_type expected_fields[$];
   int checked;
   int mismatches;

   function new();
      delim_bytes = dfs_pkg::RESET_DELIMITER_BYTES;
      delim_len   = dfs_pkg::RESET_DELIMITER_LENGTH;
      skip_empty  = 1'b0;
      checked     = 0;
      mismatches  = 0;
      clear_record();
   endfunction

   function void clear_record();
      window        = '0;
      position      = 0;
      field_begin   = 0;
      fields_taken  = 0;
      overflow_seen = 1'b0;
   endfunction

   function void write_register(dfs_pkg::csr_index_type idx, logic [63:0] value);
      case (idx)
         dfs_pkg::CSR_DELIMITER_BYTES:  delim_bytes = value;
         dfs_pkg::CSR_DELIMITER_LENGTH: delim_len = value[3:0];
         dfs_pkg::CSR_SKIP_EMPTY:       skip_empty = value[0];
         default: ;
      endcase
   endfunction

   // Lengths out of range are folded into 1 .. MAX_DELIM.
   function int span();
      int n;
      n = delim_len;
      if (n < 1) n = 1;
      if (n > dfs_pkg::DEFAULT_MAX_DELIM) n = dfs_pkg::DEFAULT_MAX_DELIM;
      return n;
   endfunction

   function bit window_matches(int n);
      for (int i = 0; i < n; i++) begin
         if (delim_bytes[8*i +: 8] != window[8*(n-1-i) +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function bit take_field(int len, output int idx);
      idx = 0;
      if (len == 0 && skip_empty) return 1'b0;
      if (fields_taken >= dfs_pkg::DEFAULT_MAX_FIELDS) begin
         overflow_seen = 1'b1;
         return 1'b0;
      end
      idx = fields_taken;
      fields_taken++;
      return 1'b1;
   endfunction

   function void add_result(bit present, int start, int len, int idx, bit done);
      dfs_pkg::result_type r;
      if (present && start > dfs_pkg::DEFAULT_MAX_LEN - 1) start = dfs_pkg::DEFAULT_MAX_LEN - 1;
      r.field_present = present;
      r.field_start   = present ? 12'(start) : 12'd0;
      r.field_length  = present ? 13'(len) : 13'd0;
      r.field_index   = present ? 8'(idx) : 8'd0;
      r.record_done   = done;
      r.field_count   = 9'(fields_taken);
      r.overflow      = overflow_seen;
      expected_fields.push_back(r);
   endfunction

   function void note_byte(logic [7:0] value, bit closes);
      int  n;
      int  idx;
      int  len;
      bit  keep;
      if (position < dfs_pkg::DEFAULT_MAX_LEN) begin
         n = span();
         window = {window[55:0], value};
         position++;
         if (position >= n && position - n >= field_begin && window_matches(n)) begin
            len = position - n - field_begin;
            if (take_field(len, idx)) add_result(1'b1, field_begin, len, idx, 1'b0);
            field_begin = position;
         end
      end else begin
         overflow_seen = 1'b1;
      end
      if (closes) begin
         len  = position - field_begin;
         keep = take_field(len, idx);
         add_result(keep, field_begin, len, idx, 1'b1);
         clear_record();
      end
   endfunction

   function string describe(dfs_pkg::result_type r);
      return $sformatf("present=%0d start=%0d length=%0d index=%0d done=%0d count=%0d ovf=%0d",
                       r.field_present, r.field_start, r.field_length, r.field_index,
                       r.record_done, r.field_count, r.overflow);
   endfunction

   function void check_result(dfs_pkg::result_type got);
      dfs_pkg::result_type want;
      checked++;
      if (expected_fields.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result beat: %s", describe(got));
         return;
      end
      want = expected_fields.pop_front();
      if (got.field_present !== want.field_present || got.field_start !== want.field_start ||
          got.field_length !== want.field_length || got.field_index !== want.field_index ||
          got.record_done !== want.record_done || got.field_count !== want.field_count ||
          got.overflow !== want.overflow) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Result beat %0d differs", checked);
            $display("   expected %s", describe(want));
            $display("   actual   %s", describe(got));
         end
      end
   endfunction

   function void report_leftover();
      while (expected_fields.size() > 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Result beat never arrived: %s", describe(expected_fields[0]));
         void'(expected_fields.pop_front());
      end
   endfunction

   function int pending();
      return expected_fields.size();
   endfunction
endclass

module delimited_field_splitter_test;

   localparam int STALL_LIMIT = 5000;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_record = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_field_present;
   logic [11:0] rsp_field_start;
   logic [12:0] rsp_field_length;
   logic [7:0]  rsp_field_index;
   logic        rsp_record_done;
   logic [8:0]  rsp_field_count;
   logic        rsp_overflow;

   logic                           csr_write_enable = 1'b0;
   dfs_pkg::csr_index_type         csr_index = dfs_pkg::CSR_DELIMITER_BYTES;
   logic [dfs_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   logic rsp_hold = 1'b0;
   int   req_idle_pct = 13;
   int   rsp_idle_pct = 67;
   int   quiet_cycles = 0;
   int   bytes_sent = 0;
   int   records_sent = 0;
   int   settings_written = 0;

   split_ledger book = new();

   delimited_field_splitter uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_record (req_end_of_record),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_field_present (rsp_field_present),
      .rsp_field_start   (rsp_field_start),
      .rsp_field_length  (rsp_field_length),
      .rsp_field_index   (rsp_field_index),
      .rsp_record_done   (rsp_record_done),
      .rsp_field_count   (rsp_field_count),
      .rsp_overflow      (rsp_overflow),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result(dfs_pkg::result_type'{rsp_field_present, rsp_field_start,
                                                 rsp_field_length, rsp_field_index,
                                                 rsp_record_done, rsp_field_count,
                                                 rsp_overflow});
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("No beat moved for %0d cycles.", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task send_byte(input logic [7:0] value, input bit closes);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= value;
      req_end_of_record <= closes;
      do @(posedge clock); while (!req_ready);
      book.note_byte(value, closes);
      bytes_sent++;
      if (closes) records_sent++;
   endtask

   task send_text(input string s, input bit closes);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], closes && i == s.len() - 1);
   endtask

   task settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task configure(input logic [63:0] delim, input logic [3:0] len, input bit skip);
      csr_write_enable <= 1'b1;
      csr_index        <= dfs_pkg::CSR_DELIMITER_BYTES;
      csr_write_data   <= delim;
      @(posedge clock);
      book.write_register(dfs_pkg::CSR_DELIMITER_BYTES, delim);
      csr_index      <= dfs_pkg::CSR_DELIMITER_LENGTH;
      csr_write_data <= 64'(len);
      @(posedge clock);
      book.write_register(dfs_pkg::CSR_DELIMITER_LENGTH, 64'(len));
      csr_index      <= dfs_pkg::CSR_SKIP_EMPTY;
      csr_write_data <= 64'(skip);
      @(posedge clock);
      book.write_register(dfs_pkg::CSR_SKIP_EMPTY, 64'(skip));
      csr_write_enable <= 1'b0;
      settings_written++;
   endtask

   function automatic logic [7:0] content_byte();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) return 8'($urandom_range(255));
      if (pick < 8) return book.delim_bytes[8*$urandom_range(book.span() - 1) +: 8];
      if (pick == 8) return 8'h00;
      return 8'hFF;
   endfunction

   task send_random_record();
      logic [7:0] record_bytes[$];
      int fields;
      int flen;
      int n;
      int cut;
      n      = book.span();
      fields = $urandom_range(6);
      for (int f = 0; f < fields; f++) begin
         flen = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         for (int k = 0; k < flen; k++) record_bytes.push_back(content_byte());
         if (f < fields - 1 || $urandom_range(1) == 1) begin
            cut = n;
            if (n > 1 && $urandom_range(9) == 0) cut = $urandom_range(1, n - 1);
            for (int i = 0; i < cut; i++) record_bytes.push_back(book.delim_bytes[8*i +: 8]);
         end
      end
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 4)) record_bytes.push_back(8'($urandom_range(255)));
      if (record_bytes.size() == 0) record_bytes.push_back(content_byte());
      foreach (record_bytes[i]) send_byte(record_bytes[i], i == record_bytes.size() - 1);
   endtask

   task random_setting();
      logic [63:0] delim;
      logic [3:0]  len;
      case ($urandom_range(4))
         0: delim = {$urandom, $urandom};
         1: delim = {8{8'($urandom_range(255))}};
         2: delim = 64'd44;
         3: delim = '0;
         default: delim = '1;
      endcase
      case ($urandom_range(5))
         0: len = 4'd0;
         1: len = 4'd15;
         2: len = 4'd8;
         3: len = 4'd1;
         default: len = 4'($urandom_range(15));
      endcase
      configure(delim, len, 1'($urandom_range(1)));
   endtask

   initial begin
      int goal;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings straight out of reset: a comma, one byte long, empty fields reported.
      send_byte(8'h00, 1'b0);
      send_text(",,", 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text(",", 1'b1);
      send_text("A", 1'b1);
      settle();
      configure(64'd44, 4'd1, 1'b1);
      send_text(",,x,", 1'b1);
      settle();
      // The record opened after the next register change stays open across the one after it.
      configure(64'h5958, 4'd2, 1'b0);
      send_text("qXYr", 1'b0);
      settle();
      configure(64'h5958, 4'd0, 1'b0);
      send_text("Xs", 1'b1);
      settle();
      configure('1, 4'd15, 1'b1);
      repeat (9) send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();

      // Field count limit.
      configure(64'd44, 4'd1, 1'b0);
      repeat (300) send_byte(",", 1'b0);
      send_byte("z", 1'b1);

      for (int regime = 0; regime < 3; regime++) begin
         req_idle_pct = (regime == 0) ? 13 : (regime == 1) ? 67 : 0;
         rsp_idle_pct = (regime == 0) ? 67 : (regime == 1) ? 13 : 0;
         for (int s = 0; s < 4; s++) begin
            settle();
            random_setting();
            if (regime == 0 && s == 1) begin
               fork
                  begin
                     rsp_hold <= 1'b1;
                     repeat (300) @(posedge clock);
                     rsp_hold <= 1'b0;
                  end
               join_none
            end
            goal = bytes_sent + 45;
            while (bytes_sent < goal) send_random_record();
         end
      end

      settle();
      repeat (16) @(posedge clock);
      book.report_leftover();
      $display("Sent %0d byte beats in %0d records over %0d register settings;",
               bytes_sent, records_sent, settings_written);
      $display("%0d result beats checked. Covered the field limit, delimiter lengths 0 to 15,",
               book.checked);
      $display("empty fields with and without skipping, and a long receiver stall.");
      if (book.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches in total.", book.mismatches);
         $display("FAILURE");
      end
      $finish;
   end
endmodule
